// ===== rtl/trilinear_volume_interpolator_assert.svh =====
// assertion macros for the trilinear volume interpolator
// included by rtl modules; empty bodies when SYNTHESIS is defined
`ifndef TRILINEAR_VOLUME_INTERPOLATOR_ASSERT_SVH
`define TRILINEAR_VOLUME_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPL(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tvi_pkg.sv =====
// shared constants and types for the trilinear volume interpolator
// no dependencies
`timescale 1ns / 1ps

package tvi_pkg;

    localparam int MAX_DIM   = 32;
    localparam int DIM_W     = 6;
    localparam int IDX_W     = 5;
    localparam int VOL_DEPTH = 32768;
    localparam int VOL_AW    = 15;
    localparam int VAL_W     = 32;
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int WF_W      = 17;
    localparam int WXY_W     = 34;
    localparam int W_W       = 49;
    localparam int SUM_W     = 84;

    localparam logic signed [VAL_W-1:0] OOR_VALUE = -32'sd65536000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_PLANES = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic oor;
    } tok_t;

endpackage

// ===== rtl/trilinear_volume_interpolator.sv =====
// Trilinear interpolator over a 32x32x32 volume of signed Q16.16 voxels held in
// a single-port on-chip memory. A write word does not stall the input. A query
// in range stalls the input while its eight corners are read through the memory
// port in turn, so the next word is taken only after the last corner read; its
// result then leaves through the 6-stage multiply and accumulate pipeline. An
// out-of-range query reads no corners and does not stall the input.
// Output stalls freeze the whole pipeline.
// Depends on tvi_pkg and trilinear_volume_interpolator_assert.svh
`timescale 1ns / 1ps
`include "trilinear_volume_interpolator_assert.svh"

module trilinear_volume_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [tvi_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [tvi_pkg::VOL_AW-1:0]          voxel_index,
    input  logic signed [tvi_pkg::VAL_W-1:0]    voxel_value,
    input  logic [tvi_pkg::COORD_W-1:0]         coord_x,
    input  logic [tvi_pkg::COORD_W-1:0]         coord_y,
    input  logic [tvi_pkg::COORD_W-1:0]         coord_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tvi_pkg::VAL_W-1:0]    interp_value,
    output logic                                out_of_range
);
    import tvi_pkg::*;

    logic [DIM_W-1:0] rows_reg, cols_reg, planes_reg;
    logic [DIM_W-1:0] rows_eff, cols_eff, planes_eff;
    logic [10:0] rc_c;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ix_reg, iy_reg, iz_reg;
    logic [FRAC_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [DIM_W-1:0] rows_q_reg;
    logic [10:0] rc_q_reg;

    logic adv, acc, run, in_rng;
    logic wr_en, rd_en;
    logic [VOL_AW-1:0] rd_addr;
    logic [WF_W-1:0] wx_sel, wy_sel, wz_sel;
    logic [15:0] addr_full;

    logic [VAL_W-1:0] mem [VOL_DEPTH];
    logic signed [VAL_W-1:0] rd_reg;

    tok_t tok1_next, tok1_reg, tok2_reg, tok3_reg, tok4_reg;
    logic [WXY_W-1:0] wxy_reg;
    logic [WF_W-1:0] wz_reg;
    logic [W_W-1:0] w_reg;
    logic signed [VAL_W-1:0] d2_reg;
    logic signed [57:0] ph_reg;
    logic signed [56:0] pl_reg;
    logic signed [SUM_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0] acc_reg, sum_c;
    logic signed [SUM_W-1:0] fin_sum_reg;
    logic fin_valid_reg, fin_oor_reg;
    logic signed [35:0] q_c;
    logic signed [VAL_W-1:0] sat_c;
    logic out_valid_reg, out_of_range_reg;
    logic signed [VAL_W-1:0] interp_value_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= DIM_W'(MAX_DIM);
            cols_reg   <= DIM_W'(MAX_DIM);
            planes_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROWS)
                rows_reg <= cfg_data;
            if (cfg_index == REG_COLS)
                cols_reg <= cfg_data;
            if (cfg_index == REG_PLANES)
                planes_reg <= cfg_data;
        end
    end

    assign rows_eff   = (rows_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_reg;
    assign cols_eff   = (cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_reg;
    assign planes_eff = (planes_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : planes_reg;
    assign rc_c       = 11'(rows_eff) * 11'(cols_eff);

    // input side and corner sequencer
    assign adv      = !out_valid_reg || !out_stall;
    assign run      = (state_reg == ST_RUN);
    assign in_stall = run || !adv;
    assign acc      = in_valid && !in_stall;
    assign in_rng   = (coord_x[23:16] != 8'd0) && (coord_x[23:16] < 8'(cols_eff))
                   && (coord_y[23:16] != 8'd0) && (coord_y[23:16] < 8'(rows_eff))
                   && (coord_z[23:16] != 8'd0) && (coord_z[23:16] < 8'(planes_eff));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && func == FUNC_QUERY && in_rng)
                begin
                    state_next = ST_RUN;
                    cnt_next   = 3'd0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && func == FUNC_QUERY)
        begin
            ix_reg     <= IDX_W'(coord_x[23:16] - 8'd1);
            iy_reg     <= IDX_W'(coord_y[23:16] - 8'd1);
            iz_reg     <= IDX_W'(coord_z[23:16] - 8'd1);
            fx_reg     <= coord_x[FRAC_W-1:0];
            fy_reg     <= coord_y[FRAC_W-1:0];
            fz_reg     <= coord_z[FRAC_W-1:0];
            rows_q_reg <= rows_eff;
            rc_q_reg   <= rc_c;
        end
    end

    // corner address and weights
    assign addr_full = 16'(iy_reg + IDX_W'(cnt_reg[1]))
                     + 16'(ix_reg + IDX_W'(cnt_reg[0])) * 16'(rows_q_reg)
                     + 16'(iz_reg + IDX_W'(cnt_reg[2])) * 16'(rc_q_reg);
    assign rd_addr = addr_full[VOL_AW-1:0];
    assign wx_sel  = cnt_reg[0] ? {1'b0, fx_reg} : 17'h10000 - {1'b0, fx_reg};
    assign wy_sel  = cnt_reg[1] ? {1'b0, fy_reg} : 17'h10000 - {1'b0, fy_reg};
    assign wz_sel  = cnt_reg[2] ? {1'b0, fz_reg} : 17'h10000 - {1'b0, fz_reg};

    assign wr_en = acc && func == FUNC_WRITE;
    assign rd_en = run && adv;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[voxel_index] <= voxel_value;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        tok1_next.valid = rd_en || (acc && func == FUNC_QUERY && !in_rng);
        tok1_next.first = !run || cnt_reg == 3'd0;
        tok1_next.last  = !run || cnt_reg == 3'd7;
        tok1_next.oor   = !run;
    end

    // multiply and accumulate pipeline
    assign prod_next = $signed({{2{ph_reg[57]}}, ph_reg, 24'd0})
                     + $signed({{27{pl_reg[56]}}, pl_reg});
    assign sum_c     = (tok4_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg      <= '0;
            tok2_reg      <= '0;
            tok3_reg      <= '0;
            tok4_reg      <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tok1_reg      <= tok1_next;
            tok2_reg      <= tok1_reg;
            tok3_reg      <= tok2_reg;
            tok4_reg      <= tok3_reg;
            fin_valid_reg <= tok4_reg.valid && tok4_reg.last;
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wxy_reg     <= WXY_W'(wx_sel) * WXY_W'(wy_sel);
            wz_reg      <= wz_sel;
            w_reg       <= W_W'(wxy_reg) * W_W'(wz_reg);
            d2_reg      <= rd_reg;
            ph_reg      <= $signed({1'b0, w_reg[48:24]}) * d2_reg;
            pl_reg      <= $signed({1'b0, w_reg[23:0]}) * d2_reg;
            prod_reg    <= prod_next;
            fin_sum_reg <= sum_c;
            fin_oor_reg <= tok4_reg.oor;
            if (tok4_reg.valid)
                acc_reg <= sum_c;
            out_of_range_reg <= fin_oor_reg;
            interp_value_reg <= fin_oor_reg ? OOR_VALUE : sat_c;
        end
    end

    // truncate toward zero and saturate
    assign q_c = $signed(fin_sum_reg[83:48])
               + $signed({35'd0, fin_sum_reg[83] && (fin_sum_reg[47:0] != 48'd0)});

    always_comb
    begin
        priority if (q_c > 36'sd2147483647)
            sat_c = 32'sh7fffffff;
        else if (q_c < -36'sd2147483648)
            sat_c = 32'sh80000000;
        else
            sat_c = q_c[VAL_W-1:0];
    end

    assign out_valid    = out_valid_reg;
    assign interp_value = interp_value_reg;
    assign out_of_range = out_of_range_reg;

    `AST_NEXT(a_query_runs, clk, rst_n, acc && func == FUNC_QUERY && in_rng, state_reg == ST_RUN)
    `AST_IMPL(a_port_excl, clk, rst_n, wr_en, !rd_en)
    `AST_IMPL(a_take_idle, clk, rst_n, !in_stall, state_reg == ST_IDLE)
    `AST_IMPL(a_oor_value, clk, rst_n, out_valid_reg && out_of_range_reg, interp_value == OOR_VALUE)

endmodule

// ===== sim/tb.sv =====
// testbench for the trilinear volume interpolator: directed and random voxel writes and
// queries, checked against a behavioral trilinear predictor with its own volume copy
// depends on tvi_pkg and the trilinear_volume_interpolator rtl
`timescale 1ns / 1ps

module tb;
    import tvi_pkg::*;

    typedef struct packed {
        logic              fn;
        logic [14:0]       idx;
        logic [31:0]       val;
        logic [23:0]       cx;
        logic [23:0]       cy;
        logic [23:0]       cz;
    } word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        oor;
    } answer_t;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_ROWS;
    logic [DIM_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_WRITE;
    logic [VOL_AW-1:0] voxel_index = '0;
    logic signed [VAL_W-1:0] voxel_value = '0;
    logic [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [VAL_W-1:0] interp_value;
    logic out_of_range;

    trilinear_volume_interpolator dut (.*);

    always #10 clk = ~clk;

    word_t   pending[$];
    answer_t expected_answers[$];
    logic [31:0] volume_copy[VOL_DEPTH];
    bit          written[VOL_DEPTH];
    int rows_cfg = 32, cols_cfg = 32, planes_cfg = 32;
    int errors = 0, queries = 0, oor_seen = 0, writes_sent = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit in_taken = 1'b0;
    int send_gap = 0, recv_gap = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic int clip_dim(input int d);
        return d > MAX_DIM ? MAX_DIM : d;
    endfunction

    function automatic answer_t trilinear(input word_t w);
        answer_t a;
        int r, c, p;
        longint ix, iy, iz, addr;
        longint fx[2], fy[2], fz[2];
        logic signed [127:0] acc, wt, q;
        r = clip_dim(rows_cfg); c = clip_dim(cols_cfg); p = clip_dim(planes_cfg);
        if (w.cx < 24'h10000 || w.cx >= (c << 16) || w.cy < 24'h10000 ||
            w.cy >= (r << 16) || w.cz < 24'h10000 || w.cz >= (p << 16))
        begin
            a.value = OOR_VALUE;
            a.oor = 1'b1;
            return a;
        end
        ix = (w.cx >> 16) - 1; iy = (w.cy >> 16) - 1; iz = (w.cz >> 16) - 1;
        fx[1] = w.cx[15:0]; fx[0] = 65536 - fx[1];
        fy[1] = w.cy[15:0]; fy[0] = 65536 - fy[1];
        fz[1] = w.cz[15:0]; fz[0] = 65536 - fz[1];
        acc = 0;
        for (int dz = 0; dz < 2; dz++)
            for (int dy = 0; dy < 2; dy++)
                for (int dx = 0; dx < 2; dx++)
                begin
                    addr = ((iy + dy) + (ix + dx) * r + (iz + dz) * r * c) % VOL_DEPTH;
                    wt = fx[dx] * fy[dy] * fz[dz];
                    acc += wt * $signed(volume_copy[addr]);
                end
        q = acc / (128'sd1 <<< 48);
        if (q > 128'sd2147483647) q = 128'sd2147483647;
        if (q < -128'sd2147483648) q = -128'sd2147483648;
        a.value = q[31:0];
        a.oor = 1'b0;
        return a;
    endfunction

    function automatic bit trilinear_oor(input word_t w);
        int r, c, p;
        r = clip_dim(rows_cfg); c = clip_dim(cols_cfg); p = clip_dim(planes_cfg);
        return w.cx < 24'h10000 || w.cx >= (c << 16) || w.cy < 24'h10000 ||
            w.cy >= (r << 16) || w.cz < 24'h10000 || w.cz >= (p << 16);
    endfunction

    // a query is safe when every corner it would read was written
    function automatic bit corners_written(input word_t w);
        int r, c;
        longint ix, iy, iz, addr;
        r = clip_dim(rows_cfg); c = clip_dim(cols_cfg);
        if (trilinear_oor(w)) return 1'b1;
        ix = (w.cx >> 16) - 1; iy = (w.cy >> 16) - 1; iz = (w.cz >> 16) - 1;
        for (int k = 0; k < 8; k++)
        begin
            addr = ((iy + k[1]) + (ix + k[0]) * r + (iz + k[2]) * r * c) % VOL_DEPTH;
            if (!written[addr]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (in_valid)
                begin
                    if (func == FUNC_WRITE) writes_sent++;
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    word_t w;
                    w = pending.pop_front();
                    in_valid <= 1'b1;
                    func <= w.fn;
                    voxel_index <= w.idx;
                    voxel_value <= w.val;
                    coord_x <= w.cx;
                    coord_y <= w.cy;
                    coord_z <= w.cz;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
                end
                else
                    in_valid <= 1'b0;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 8);
            end
        end
    end

    // monitor: predicts at input acceptance, checks at output acceptance
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                idle_cycles = 0;
                if (func == FUNC_QUERY)
                    expected_answers.push_back(trilinear({func, voxel_index, voxel_value,
                        coord_x, coord_y, coord_z}));
                else
                    volume_copy[voxel_index] = voxel_value;
            end
            if (cfg_valid && cfg_ready) idle_cycles = 0;
            if (out_valid && !out_stall)
            begin
                answer_t e;
                idle_cycles = 0;
                if (expected_answers.size() == 0)
                    report("word with no query waiting");
                else
                begin
                    e = expected_answers.pop_front();
                    queries++;
                    if (e.oor) oor_seen++;
                    if (interp_value !== e.value)
                        report($sformatf("interp_value %0d want %0d",
                            interp_value, $signed(e.value)));
                    if (out_of_range !== e.oor)
                        report($sformatf("out_of_range %b want %b", out_of_range, e.oor));
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout");
                $display("tb: errors");
                $finish;
            end
        end
    end

    // written marks follow the queue so queries only go out over filled corners
    task automatic add_write(input int idx, input logic [31:0] v);
        word_t w;
        w = '0;
        w.fn = FUNC_WRITE; w.idx = 15'(idx); w.val = v;
        w.cx = 24'($urandom); w.cy = 24'($urandom); w.cz = 24'($urandom);
        written[idx] = 1'b1;
        pending.push_back(w);
    endtask

    task automatic add_query(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
        word_t w;
        w.fn = FUNC_QUERY; w.idx = 15'($urandom); w.val = $urandom;
        w.cx = x; w.cy = y; w.cz = z;
        if (corners_written(w)) pending.push_back(w);
    endtask

    task automatic drain();
        while (pending.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DIM_W'(v);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ROWS) rows_cfg = v;
        else if (idx == REG_COLS) cols_cfg = v;
        else planes_cfg = v;
    endtask

    function automatic logic [23:0] rand_coord(input int d);
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return {8'($urandom_range(0, d + 1)), 16'h0};
            2: return {8'($urandom_range(1, d)), $urandom_range(0, 1) ? 16'hFFFF : 16'h0001};
            default: return {8'(($urandom_range(1, d > 1 ? d - 1 : 1))), 16'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_volume(input bit extremes);
        int n;
        n = clip_dim(rows_cfg) * clip_dim(cols_cfg) * clip_dim(planes_cfg);
        if (n > VOL_DEPTH) n = VOL_DEPTH;
        for (int i = 0; i < n; i++)
            if (extremes) add_write(i, i[0] ? 32'h7FFFFFFF : 32'h80000000);
            else if (!written[i] || $urandom_range(0, 3) == 0) add_write(i, rand_value());
    endtask

    task automatic random_phase(input int r, input int c, input int p, input int n);
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        write_reg(REG_PLANES, p);
        fill_volume(1'b0);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 7) == 0)
                add_write($urandom_range(0, r * c * p - 1), rand_value());
            else
                add_query(rand_coord(c), rand_coord(r), rand_coord(p));
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: small volume of extremes, corner and edge points
        write_reg(REG_ROWS, 2);
        write_reg(REG_COLS, 2);
        write_reg(REG_PLANES, 2);
        fill_volume(1'b1);
        add_query(24'h010000, 24'h010000, 24'h010000);
        add_query(24'h01FFFF, 24'h01FFFF, 24'h01FFFF);
        add_query(24'h018000, 24'h018000, 24'h018000);
        add_query(24'h00FFFF, 24'h010000, 24'h010000);
        add_query(24'h020000, 24'h010000, 24'h010000);
        add_query(24'h010000, 24'h000000, 24'h010000);
        add_query(24'h010000, 24'h010000, 24'hFFFFFF);
        add_query(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_write(0, 32'h7FFFFFFF); add_write(1, 32'h7FFFFFFF);
        add_write(2, 32'h7FFFFFFF); add_write(3, 32'h7FFFFFFF);
        add_query(24'h01C000, 24'h014000, 24'h010000);
        drain();
        // zero dimension and oversize dimension
        write_reg(REG_ROWS, 0);
        add_query(24'h010000, 24'h010000, 24'h010000);
        drain();
        write_reg(REG_ROWS, 63);
        write_reg(REG_COLS, 1);
        write_reg(REG_PLANES, 1);
        add_query(24'h010000, 24'h050000, 24'h010000);
        drain();
        random_phase(4, 3, 5, 250);
        random_phase(32, 2, 2, 250);
        random_phase(2, 5, 16, 200);
        random_phase(7, 2, 3, 200);
        quiet = 1'b1;
        random_phase(3, 3, 3, 120);
        $display("run covered %0d answers (%0d out of range) and %0d voxel writes",
            queries, oor_seen, writes_sent);
        $display("dimension settings from 0 and 1 up to 32 and a saturated 63");
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
